// ===== rtl/core/lkv_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the lru key-value cache
// no dependencies; imported by lkv_cell and lru_key_value_cache_unit
package lkv_pkg;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_SET = 1'b1;

   localparam int CAPACITY_BITS = 5;

   // broadcast from the top level to every cell of the chain
   typedef struct packed {
      logic active;
      logic is_set;
      logic evict;
      logic hit_any;
   } lkv_ctl_type;

endpackage

// ===== rtl/core/lkv_cell.sv =====
`timescale 1ns / 1ps
// one storage cell of the recency-ordered chain: compare, hit prefix, value merge, shift
// depends on lkv_pkg
module lkv_cell #(
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lkv_pkg::lkv_ctl_type  ctl,
   input  logic [KEY_BITS-1:0]   bcast_key,
   input  logic                  hit_in,
   output logic                  hit_out,
   input  logic [VALUE_BITS-1:0] rdval_in,
   output logic [VALUE_BITS-1:0] rdval_out,
   input  logic                  prev_valid,
   input  logic [KEY_BITS-1:0]   prev_key,
   input  logic [VALUE_BITS-1:0] prev_value,
   output logic                  cur_valid,
   output logic [KEY_BITS-1:0]   cur_key,
   output logic [VALUE_BITS-1:0] cur_value
);
   import lkv_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match;
   logic                  shift;

   assign match     = valid_ff && (key_ff == bcast_key);
   assign hit_out   = hit_in | match;
   assign rdval_out = rdval_in | (match ? value_ff : '0);

   // hit: cells up to and including the matching one move down
   // miss on set: whole chain moves, or only valid cells when evicting
   always_comb begin
      shift = 1'b0;
      if (ctl.active) begin
         if (ctl.hit_any) begin
            shift = !hit_in;
         end else if (ctl.is_set) begin
            shift = ctl.evict ? valid_ff : 1'b1;
         end
      end
      valid_in = shift ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end
   end

   assign cur_valid = valid_ff;
   assign cur_key   = key_ff;
   assign cur_value = value_ff;

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
// top level of the lru key-value cache: chain of lkv_cell, occupancy, capacity, result register
// depends on lkv_pkg and lkv_cell
//
// Fully associative key-value store kept as a chain of ENTRIES cells ordered by recency,
// most recent in cell 0. One item is taken per clock: the key is compared in every cell at
// once, and the hit prefix and read value ripple down the chain in the same cycle, so the
// chain length sets the clock path. A get result appears in the output register in the cycle
// after its transfer; a set gives no result. Input is stalled only while a result is held
// and the output is stalled. Capacity (0 counts as 1, above ENTRIES as ENTRIES) limits
// occupancy before the least recent entry is evicted; reset clears all entries at once.
module lru_key_value_cache_unit #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [KEY_BITS-1:0]                   req_key,
   input  logic [VALUE_BITS-1:0]                 req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [VALUE_BITS-1:0]                 rsp_read_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lkv_pkg::CAPACITY_BITS-1:0]     csr_capacity
);
   import lkv_pkg::*;

   localparam int OCC_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS = (OCC_BITS > CAPACITY_BITS) ? OCC_BITS : CAPACITY_BITS;

   logic [CAPACITY_BITS-1:0] capacity_ff;
   logic [OCC_BITS-1:0]      occ_ff;
   logic [OCC_BITS-1:0]      occ_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_hit_ff;
   logic [VALUE_BITS-1:0]    rsp_read_value_ff;

   logic                     req_xfer;
   logic                     rsp_xfer;
   logic                     fill;
   logic [CMP_BITS-1:0]      cap_ext;
   logic [CMP_BITS-1:0]      eff_cap;
   lkv_ctl_type              ctl;

   logic [ENTRIES:0]         hit_chain;
   logic [VALUE_BITS-1:0]    rdval_chain [ENTRIES+1];
   logic [ENTRIES-1:0]       valid_vec;
   logic [KEY_BITS-1:0]      key_vec     [ENTRIES];
   logic [VALUE_BITS-1:0]    value_vec   [ENTRIES];
   logic [VALUE_BITS-1:0]    front_value;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      cap_ext = CMP_BITS'(capacity_ff);
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
         eff_cap = CMP_BITS'(ENTRIES);
      end
      fill = CMP_BITS'(occ_ff) < eff_cap;
   end

   assign hit_chain[0]   = 1'b0;
   assign rdval_chain[0] = '0;

   always_comb begin
      ctl.active  = req_xfer;
      ctl.is_set  = (req_kind == KIND_SET);
      ctl.evict   = !fill;
      ctl.hit_any = hit_chain[ENTRIES];
   end

   assign front_value = (req_kind == KIND_SET) ? req_value : rdval_chain[ENTRIES];

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         logic                  prev_valid;
         logic [KEY_BITS-1:0]   prev_key;
         logic [VALUE_BITS-1:0] prev_value;

         if (gi == 0) begin : g_front
            assign prev_valid = 1'b1;
            assign prev_key   = req_key;
            assign prev_value = front_value;
         end else begin : g_link
            assign prev_valid = valid_vec[gi-1];
            assign prev_key   = key_vec[gi-1];
            assign prev_value = value_vec[gi-1];
         end

         lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .bcast_key  (req_key),
            .hit_in     (hit_chain[gi]),
            .hit_out    (hit_chain[gi+1]),
            .rdval_in   (rdval_chain[gi]),
            .rdval_out  (rdval_chain[gi+1]),
            .prev_valid (prev_valid),
            .prev_key   (prev_key),
            .prev_value (prev_value),
            .cur_valid  (valid_vec[gi]),
            .cur_key    (key_vec[gi]),
            .cur_value  (value_vec[gi])
         );
      end
   endgenerate

   // occupancy grows only on a set of a new key with room left
   always_comb begin
      occ_in = occ_ff;
      if (req_xfer && (req_kind == KIND_SET) && !hit_chain[ENTRIES] && fill) begin
         occ_in = OCC_BITS'(occ_ff + 1'b1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer && (req_kind == KIND_GET)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_BITS'(16);
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (req_kind == KIND_GET)) begin
         rsp_hit_ff        <= hit_chain[ENTRIES];
         rsp_read_value_ff <= rdval_chain[ENTRIES];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(ENTRIES))
      else $error("occupancy above entry count");

   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(occ_ff))
      else $error("valid cells disagree with occupancy");

   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + 1'b1))
      else $error("valid cells not packed toward the front");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_read_value_ff == '0)
      else $error("miss result carries a nonzero value");

   a_occ_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (occ_ff != $past(occ_ff))
         |-> $past(req_xfer && (req_kind == KIND_SET)))
      else $error("occupancy moved without a set transfer");
`endif

endmodule

// ===== verif/tb_lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
// testbench for lru_key_value_cache_unit: directed lookup, eviction and capacity cases,
// then random get/set traffic per capacity setting with random gaps and stalls
// depends on lkv_pkg and the cache rtl; an in-bench lru store predicts every get result

module tb_lru_key_value_cache_unit;
   import lkv_pkg::*;

   localparam int ENTRY_COUNT = 16;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 63;

   typedef struct packed {
      logic        hit;
      logic [15:0] read_value;
   } lookup_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_kind = KIND_GET;
   logic [15:0]              req_key = '0;
   logic [15:0]              req_value = '0;
   logic                     rsp_stall = 1'b0;
   logic                     csr_valid = 1'b0;
   logic [CAPACITY_BITS-1:0] csr_capacity = '0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic                     rsp_hit;
   logic [15:0]              rsp_read_value;
   logic                     csr_ready;

   // predicted cache contents
   logic        slot_valid [ENTRY_COUNT];
   logic [15:0] slot_key [ENTRY_COUNT];
   logic [15:0] slot_value [ENTRY_COUNT];
   int          slot_age [ENTRY_COUNT];
   int          fill_count;
   int          capacity_setting;

   lookup_result_type pending_lookups [$];
   lookup_result_type expected_result;
   int                mismatch_count = 0;
   bit                req_gaps_on = 1'b1;

   lru_key_value_cache_unit #(
      .ENTRIES    (16),
      .KEY_BITS   (16),
      .VALUE_BITS (16)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int usable_capacity(input int setting);
      if (setting == 0) return 1;
      if (setting > ENTRY_COUNT) return ENTRY_COUNT;
      return setting;
   endfunction

   // entries more recent than old_age get one step older, slot s becomes most recent
   function automatic void make_most_recent(input int s, input int old_age);
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (slot_valid[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
      end
      slot_age[s] = 0;
   endfunction

   // applies one get or set to the predicted store; returns 1 when a result is due
   function automatic bit lru_access(input logic kind, input logic [15:0] key,
                                     input logic [15:0] value, output lookup_result_type res);
      int found;
      int slot;
      int worst;
      found = -1;
      slot = -1;
      worst = 0;
      res = '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      end
      if (kind == KIND_GET) begin
         if (found >= 0) begin
            res.hit = 1'b1;
            res.read_value = slot_value[found];
            make_most_recent(found, slot_age[found]);
         end
         return 1'b1;
      end
      if (found >= 0) begin
         slot_value[found] = value;
         make_most_recent(found, slot_age[found]);
      end else if (fill_count < usable_capacity(capacity_setting)) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (slot < 0 && !slot_valid[i]) slot = i;
         end
         slot_valid[slot] = 1'b1;
         slot_key[slot] = key;
         slot_value[slot] = value;
         fill_count++;
         make_most_recent(slot, ENTRY_COUNT);
      end else begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (slot_valid[i] && (slot < 0 || slot_age[i] > worst)) begin
               slot = i;
               worst = slot_age[i];
            end
         end
         slot_key[slot] = key;
         slot_value[slot] = value;
         make_most_recent(slot, worst);
      end
      return 1'b0;
   endfunction

   task automatic send_item(input logic kind, input logic [15:0] key, input logic [15:0] value);
      int gap;
      lookup_result_type res;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_key <= key;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (lru_access(kind, key, value, res)) pending_lookups.push_back(res);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input int setting);
      hold_until_drained();
      // a trailing set leaves no result to wait for
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_capacity <= CAPACITY_BITS'(setting);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity_setting = setting;
   endtask

   task automatic test_basic_lookup();
      send_item(KIND_GET, 16'h0000, 16'h0000);
      send_item(KIND_SET, 16'h0000, 16'h0000);
      send_item(KIND_GET, 16'h0000, 16'hFFFF);
      send_item(KIND_SET, 16'hFFFF, 16'hFFFF);
      send_item(KIND_GET, 16'hFFFF, 16'h0000);
      send_item(KIND_SET, 16'hFFFF, 16'h1234);
      send_item(KIND_GET, 16'hFFFF, 16'h0000);
      send_item(KIND_GET, 16'h8000, 16'hFFFF);
   endtask

   task automatic test_lru_replacement();
      write_capacity(2);
      send_item(KIND_GET, 16'h0000, 16'h0000);
      send_item(KIND_SET, 16'h00AA, 16'h5555);
      send_item(KIND_GET, 16'hFFFF, 16'h0000);
      send_item(KIND_GET, 16'h0000, 16'h0000);
      send_item(KIND_GET, 16'h00AA, 16'h0000);
   endtask

   // capacity below occupancy without reset, zero and oversized settings
   task automatic test_capacity_limits();
      write_capacity(0);
      send_item(KIND_SET, 16'h1111, 16'hAAAA);
      send_item(KIND_GET, 16'h1111, 16'h0000);
      send_item(KIND_GET, 16'h0000, 16'h0000);
      write_capacity(31);
      send_item(KIND_SET, 16'h2222, 16'h0001);
      send_item(KIND_SET, 16'h3333, 16'h8000);
      send_item(KIND_GET, 16'h2222, 16'h0000);
      send_item(KIND_GET, 16'h00AA, 16'h0000);
      send_item(KIND_GET, 16'h3333, 16'h0000);
   endtask

   task automatic test_random_traffic();
      int          cap_list [RANDOM_PHASES] = '{1, 16, 2, 31, 0, 4, 8, 3, 12, 16};
      logic [15:0] key_pool [$];
      logic [15:0] key;
      logic [15:0] value;
      logic        kind;
      int          pool_size;
      int          r;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_capacity(cap_list[phase]);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         key_pool.delete();
         pool_size = usable_capacity(cap_list[phase]) + $urandom_range(0, 4);
         for (int i = 0; i < pool_size; i++) key_pool.push_back(16'($urandom));
         key_pool.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            key = (r < 88) ? key_pool[$urandom_range(0, key_pool.size() - 1)] : 16'($urandom);
            kind = $urandom_range(0, 1) ? KIND_SET : KIND_GET;
            r = $urandom_range(0, 19);
            value = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
            send_item(kind, key, value);
            if ($urandom_range(0, 49) == 0) hold_until_drained();
         end
      end
   endtask

   initial begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i] = '0;
         slot_value[i] = '0;
         slot_age[i] = 0;
      end
      fill_count = 0;
      capacity_setting = ENTRY_COUNT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_lookup();
      test_lru_replacement();
      test_capacity_limits();
      test_random_traffic();
      hold_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_lookups.size() == 0)
         $display("tb_lru_key_value_cache_unit: clean");
      else
         $display("tb_lru_key_value_cache_unit: errors");
      $finish;
   end

   // result side back-pressure: short and long stalls, some long free stretches
   initial begin
      int n;
      bit s;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            s = 1'b0;
            n = $urandom_range(30, 100);
         end else begin
            s = $urandom_range(0, 1);
            n = s ? pick_gap() + 1 : $urandom_range(1, 4);
         end
         rsp_stall <= s;
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            $error("result transfer with no get pending");
            mismatch_count++;
         end else begin
            expected_result = pending_lookups.pop_front();
            if (rsp_hit !== expected_result.hit) begin
               $error("hit: expected %0d, actual %0d", expected_result.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_read_value !== expected_result.read_value) begin
               $error("read_value: expected %h, actual %h",
                      expected_result.read_value, rsp_read_value);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_lru_key_value_cache_unit: errors");
      $finish;
   end

endmodule
